FILE: rtl/core/fsvf_pkg.sv
// Shared types and constants of the free sector valley finder.
// Used by every module under rtl/core; depends on nothing else.
`default_nettype none

package fsvf_pkg;

  // Field widths; sector indexes cover up to 256 sectors
  localparam int SEC_W      = 8;
  localparam int POS_W      = 8;
  localparam int VAL_W      = 16;
  localparam int NW_W       = 7;
  localparam int CFG_ADDR_W = 1;
  localparam int CFG_DATA_W = 16;

  // Configuration register indexes
  localparam logic [CFG_ADDR_W-1:0] REG_FREE_THRESHOLD = 1'b0;
  localparam logic [CFG_ADDR_W-1:0] REG_NARROW_WIDTH   = 1'b1;

  // Reset values of the configuration registers
  localparam logic [VAL_W-1:0] FREE_THRESHOLD_RST = 16'd512;
  localparam logic [NW_W-1:0]  NARROW_WIDTH_RST   = 7'd10;

  // Result queue geometry
  localparam int Q_DEPTH = 4;
  localparam int Q_PTR_W = 2;
  localparam int Q_CNT_W = 3;

  // One valley report request: run bounds, or an empty end marker
  typedef struct packed {
    logic [SEC_W-1:0] run_first;
    logic [SEC_W-1:0] run_last;
    logic             marker;
    logic             eos;
  } fsvf_req_t;

  // One formatted result
  typedef struct packed {
    logic [POS_W-1:0] left_pos;
    logic [POS_W-1:0] right_pos;
    logic             is_narrow;
    logic             has_direction;
    logic             end_of_scan;
  } fsvf_res_t;

endpackage

`default_nettype wire

FILE: rtl/core/free_sector_valley_finder_core.sv
// Top level of the free sector valley finder: stream ports, configuration
// registers, run tracker, result formatter and result queue.
// Depends on fsvf_pkg, fsvf_tracker, fsvf_format and fsvf_resq.
`default_nettype none

// The block takes one histogram sector per transaction, sector 0 first, and
// reports every run of free sectors (value at or below free_threshold) as a
// valley, with runs wrapping from the last sector to sector 0. It accepts one
// sector per clock while in_tready is high. A sector is classified and the
// run state updated in the cycle it is taken; its requests are formatted the
// next cycle and enter a four-entry result queue that feeds out_*. The final
// sector of a scan can produce two results; the queue drains one per cycle
// while out_tready is high, and in_tready drops only while the queue plus the
// staged requests hold more than two results. The final sector always ends
// with a result marked by out_tlast, and the next sector starts a new scan.
// Configuration writes are meant for idle periods only.
module free_sector_valley_finder_core #(
  parameter int NUM_SECTORS = 90
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  // input stream
  input  wire logic                             in_tvalid,
  output logic                                  in_tready,
  input  wire logic [15:0]                      in_tdata,   // [15:0] sector_value
  // result stream
  output logic                                  out_tvalid,
  input  wire logic                             out_tready,
  output logic [15:0]                           out_tdata,  // [7:0] left_pos, [15:8] right_pos
  output logic [1:0]                            out_tuser,  // [0] is_narrow, [1] has_direction
  output logic                                  out_tlast,  // end_of_scan
  // configuration
  input  wire logic                             cfg_we,
  input  wire logic [fsvf_pkg::CFG_ADDR_W-1:0]  cfg_addr,
  input  wire logic [fsvf_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
  import fsvf_pkg::*;

  logic [VAL_W-1:0]   free_threshold_r;
  logic [NW_W-1:0]    narrow_width_r;
  logic               in_accept;
  fsvf_req_t          req0, req1;
  logic [1:0]         req_cnt;
  fsvf_res_t          res0, res1, head;
  logic [Q_CNT_W-1:0] q_count;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      free_threshold_r <= FREE_THRESHOLD_RST;
      narrow_width_r   <= NARROW_WIDTH_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_FREE_THRESHOLD: free_threshold_r <= cfg_wdata[VAL_W-1:0];
        REG_NARROW_WIDTH:   narrow_width_r   <= cfg_wdata[NW_W-1:0];
        default: ;
      endcase
    end
  end

  // Room for two more results once staged requests are queued
  assign in_tready = (q_count + Q_CNT_W'(req_cnt)) <= Q_CNT_W'(Q_DEPTH - 2);
  assign in_accept = in_tvalid && in_tready;

  fsvf_tracker #(
    .NUM_SECTORS (NUM_SECTORS)
  ) u_tracker (
    .clk            (clk),
    .rst_n          (rst_n),
    .accept         (in_accept),
    .sector_value   (in_tdata[VAL_W-1:0]),
    .free_threshold (free_threshold_r),
    .req0           (req0),
    .req1           (req1),
    .req_cnt        (req_cnt)
  );

  fsvf_format #(
    .NUM_SECTORS (NUM_SECTORS)
  ) u_format0 (
    .req          (req0),
    .narrow_width (narrow_width_r),
    .res          (res0)
  );

  fsvf_format #(
    .NUM_SECTORS (NUM_SECTORS)
  ) u_format1 (
    .req          (req1),
    .narrow_width (narrow_width_r),
    .res          (res1)
  );

  fsvf_resq u_resq (
    .clk   (clk),
    .rst_n (rst_n),
    .push0 (req_cnt != 2'd0),
    .push1 (req_cnt == 2'd2),
    .data0 (res0),
    .data1 (res1),
    .pop   (out_tvalid && out_tready),
    .head  (head),
    .count (q_count)
  );

  // Result stream
  assign out_tvalid = q_count != '0;
  assign out_tdata  = {head.right_pos, head.left_pos};
  assign out_tuser  = {head.has_direction, head.is_narrow};
  assign out_tlast  = head.end_of_scan;

endmodule

`default_nettype wire

FILE: rtl/core/fsvf_tracker.sv
// Run tracker: classifies each sector, follows free runs across the scan
// and registers up to two report requests per sector. Depends on fsvf_pkg.
`default_nettype none

module fsvf_tracker #(
  parameter int NUM_SECTORS = 90
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      accept,
  input  wire logic [fsvf_pkg::VAL_W-1:0] sector_value,
  input  wire logic [fsvf_pkg::VAL_W-1:0] free_threshold,
  output fsvf_pkg::fsvf_req_t            req0,
  output fsvf_pkg::fsvf_req_t            req1,
  output logic [1:0]                     req_cnt
);
  import fsvf_pkg::*;

  localparam logic [SEC_W-1:0] LAST_IDX = SEC_W'(NUM_SECTORS - 1);

  // Scan state
  logic [SEC_W-1:0] idx_r, idx_nxt;
  logic             open_r, open_nxt;
  logic [SEC_W-1:0] run_first_r, run_first_nxt;
  logic             frc_r, frc_nxt;
  logic [SEC_W-1:0] frl_r, frl_nxt;

  // Request stage
  fsvf_req_t  req0_r, req0_nxt, req1_r, req1_nxt;
  logic [1:0] cnt_r, cnt_nxt;

  logic             is_free, is_final;
  logic             open_now, close_rep, close_first;
  logic             open_a, frc_a, tail_valid;
  logic [SEC_W-1:0] first_a, frl_a, prev_idx;
  fsvf_req_t        close_req, tail_req;

  always_comb begin
    is_free  = sector_value <= free_threshold;
    is_final = idx_r >= LAST_IDX;
    prev_idx = idx_r - SEC_W'(1);

    // run open / close events at this sector
    open_now    = is_free && !open_r;
    close_rep   = !is_free && open_r && (run_first_r != '0);
    close_first = !is_free && open_r && (run_first_r == '0);

    open_a  = open_now || (open_r && is_free);
    first_a = open_now ? idx_r : run_first_r;
    if (open_now && is_final) first_a = LAST_IDX;
    frc_a   = frc_r || close_first;
    frl_a   = close_first ? prev_idx : frl_r;

    close_req.run_first = run_first_r;
    close_req.run_last  = prev_idx;
    close_req.marker    = 1'b0;
    close_req.eos       = 1'b0;

    // end of scan: open run (wrapping onto a held first run) or held run alone
    tail_valid         = open_a || frc_a;
    tail_req.run_first = open_a ? first_a : '0;
    tail_req.run_last  = (open_a && !frc_a) ? LAST_IDX : frl_a;
    tail_req.marker    = !tail_valid;
    tail_req.eos       = 1'b1;

    req0_nxt = close_req;
    req1_nxt = tail_req;
    cnt_nxt  = 2'd0;
    idx_nxt       = idx_r;
    open_nxt      = open_r;
    run_first_nxt = run_first_r;
    frc_nxt       = frc_r;
    frl_nxt       = frl_r;

    if (accept) begin
      if (is_final) begin
        if (close_rep) begin
          req0_nxt.eos = !tail_valid;
          cnt_nxt      = tail_valid ? 2'd2 : 2'd1;
        end else begin
          req0_nxt = tail_req;
          cnt_nxt  = 2'd1;
        end
        idx_nxt       = '0;
        open_nxt      = 1'b0;
        run_first_nxt = '0;
        frc_nxt       = 1'b0;
        frl_nxt       = '0;
      end else begin
        cnt_nxt       = {1'b0, close_rep};
        idx_nxt       = idx_r + SEC_W'(1);
        open_nxt      = open_a;
        run_first_nxt = first_a;
        frc_nxt       = frc_a;
        frl_nxt       = frl_a;
      end
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= '0;
      open_r      <= 1'b0;
      run_first_r <= '0;
      frc_r       <= 1'b0;
      frl_r       <= '0;
      cnt_r       <= 2'd0;
    end else begin
      idx_r       <= idx_nxt;
      open_r      <= open_nxt;
      run_first_r <= run_first_nxt;
      frc_r       <= frc_nxt;
      frl_r       <= frl_nxt;
      cnt_r       <= cnt_nxt;
    end
  end

  // Request payload
  always_ff @(posedge clk) begin
    req0_r <= req0_nxt;
    req1_r <= req1_nxt;
  end

  assign req0    = req0_r;
  assign req1    = req1_r;
  assign req_cnt = cnt_r;

endmodule

`default_nettype wire

FILE: rtl/core/fsvf_format.sv
// Result formatter: turns a run request into edge positions or a midpoint
// in half-sector units. Depends on fsvf_pkg.
`default_nettype none

module fsvf_format #(
  parameter int NUM_SECTORS = 90
) (
  input  wire fsvf_pkg::fsvf_req_t       req,
  input  wire logic [fsvf_pkg::NW_W-1:0] narrow_width,
  output fsvf_pkg::fsvf_res_t            res
);
  import fsvf_pkg::*;

  localparam int          TW   = SEC_W + 2;
  localparam logic [TW-1:0] N_X1 = TW'(NUM_SECTORS);
  localparam logic [TW-1:0] N_X2 = TW'(2 * NUM_SECTORS);

  logic [TW-1:0] first_w, last_w, span, mid_raw, mid;
  logic          narrow;

  always_comb begin
    first_w = TW'(req.run_first);
    last_w  = TW'(req.run_last);

    // span modulo the sector count
    if (last_w >= first_w) span = last_w - first_w;
    else                   span = last_w + N_X1 - first_w;

    narrow  = span < TW'(narrow_width);
    mid_raw = (first_w << 1) + span;
    mid     = (mid_raw > N_X2) ? mid_raw - N_X2 : mid_raw;

    if (req.marker) begin
      res.left_pos      = '0;
      res.right_pos     = '0;
      res.is_narrow     = 1'b0;
      res.has_direction = 1'b0;
    end else if (narrow) begin
      res.left_pos      = mid[POS_W-1:0];
      res.right_pos     = mid[POS_W-1:0];
      res.is_narrow     = 1'b1;
      res.has_direction = 1'b1;
    end else begin
      res.left_pos      = {req.run_first[POS_W-2:0], 1'b0};
      res.right_pos     = {req.run_last[POS_W-2:0], 1'b0};
      res.is_narrow     = 1'b0;
      res.has_direction = 1'b1;
    end
    res.end_of_scan = req.eos;
  end

endmodule

`default_nettype wire

FILE: rtl/core/fsvf_resq.sv
// Result queue: four entries, takes up to two results per cycle and hands
// out one per transaction. Depends on fsvf_pkg.
`default_nettype none

module fsvf_resq (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         push0,
  input  wire logic                         push1,
  input  wire fsvf_pkg::fsvf_res_t          data0,
  input  wire fsvf_pkg::fsvf_res_t          data1,
  input  wire logic                         pop,
  output fsvf_pkg::fsvf_res_t               head,
  output logic [fsvf_pkg::Q_CNT_W-1:0]      count
);
  import fsvf_pkg::*;

  fsvf_res_t            entry_r [Q_DEPTH];
  logic [Q_PTR_W-1:0]   wptr_r, wptr_nxt, rptr_r, rptr_nxt;
  logic [Q_CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [Q_CNT_W-1:0]   push_n;

  // Pointer and fill bookkeeping
  always_comb begin
    push_n   = Q_CNT_W'(push0) + Q_CNT_W'(push1);
    wptr_nxt = wptr_r + push_n[Q_PTR_W-1:0];
    rptr_nxt = rptr_r + Q_PTR_W'(pop);
    cnt_nxt  = cnt_r + push_n - Q_CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // Entry writes
  always_ff @(posedge clk) begin
    if (push0) entry_r[wptr_r] <= data0;
    if (push1) entry_r[wptr_r + Q_PTR_W'(1)] <= data1;
  end

  assign head  = entry_r[rptr_r];
  assign count = cnt_r;

endmodule

`default_nettype wire
